@@ hdl/assert_macros.svh @@
// assertion macros shared by the packet filter rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define EPCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// when the first expression holds, the second must hold in the next cycle
`define EPCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/epcf_pkg.sv @@
// types and constants for the ethernet packet class filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package epcf_pkg;

    // filter mode codes
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_HTTP  = 3'd1;
    localparam logic [2:0] MODE_HTTPS = 3'd2;
    localparam logic [2:0] MODE_DNS   = 3'd3;
    localparam logic [2:0] MODE_ARP   = 3'd4;
    localparam logic [2:0] MODE_TCP   = 3'd5;
    localparam logic [2:0] MODE_UDP   = 3'd6;

    // ethertypes
    localparam logic [15:0] ET_ARP  = 16'h0806;
    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;

    // ip protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // well-known ports
    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_DNS   = 16'd53;

    // header offsets and lengths in bytes
    localparam logic [7:0] ETH_HDR_LEN = 8'd14;
    localparam logic [7:0] IPV4_MIN_HDR = 8'd20;
    localparam logic [7:0] IPV6_HDR    = 8'd40;
    localparam logic [7:0] TCP_HDR     = 8'd20;
    localparam logic [7:0] UDP_HDR     = 8'd8;
    localparam logic [7:0] ET_HI_IDX   = 8'd12;
    localparam logic [7:0] ET_LO_IDX   = 8'd13;
    localparam logic [7:0] IHL_IDX     = 8'd14;
    localparam logic [7:0] V6_NH_IDX   = 8'd20;
    localparam logic [7:0] V4_PROTO_IDX = 8'd23;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    // config register byte address width; its top bit selects the register
    localparam int unsigned CFG_ADDR_W = 3;

    // fields captured from one frame, as seen at its last byte
    typedef struct packed {
        logic [7:0]  len;
        logic [15:0] ether_kind;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
    } frame_fields_t;

endpackage

`default_nettype wire

@@ hdl/epcf_decide.sv @@
// match decision for one finished frame
// depends on epcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module epcf_decide (
    input  wire logic [2:0]             mode,
    input  wire epcf_pkg::frame_fields_t fields,
    output logic                        match
);
    import epcf_pkg::*;

    logic [7:0] toff;
    logic [8:0] tcp_end;
    logic [8:0] udp_end;
    logic       is_v4;
    logic       is_v6;
    logic       eth_ok;
    logic       l3_ok;
    logic       tcp_ok;
    logic       udp_ok;

    // transport offset and the lengths the transport header needs
    always_comb
    begin
        is_v4   = (fields.ether_kind == ET_IPV4);
        is_v6   = (fields.ether_kind == ET_IPV6);
        toff    = is_v6 ? (ETH_HDR_LEN + IPV6_HDR)
                        : (ETH_HDR_LEN + {2'b00, fields.ihl, 2'b00});
        tcp_end = {1'b0, toff} + {1'b0, TCP_HDR};
        udp_end = {1'b0, toff} + {1'b0, UDP_HDR};
        eth_ok  = (fields.len >= ETH_HDR_LEN);
        l3_ok   = (is_v4 && (fields.len >= (ETH_HDR_LEN + IPV4_MIN_HDR)))
               || (is_v6 && (fields.len >= (ETH_HDR_LEN + IPV6_HDR)));
        tcp_ok  = l3_ok && (fields.proto == PROTO_TCP)
               && ({1'b0, fields.len} >= tcp_end);
        udp_ok  = l3_ok && (fields.proto == PROTO_UDP)
               && ({1'b0, fields.len} >= udp_end);
    end

    // per-mode match
    always_comb
    begin
        case (mode)
            MODE_NONE:  match = 1'b1;
            MODE_HTTP:  match = tcp_ok && ((fields.sport == PORT_HTTP)
                                        || (fields.dport == PORT_HTTP));
            MODE_HTTPS: match = tcp_ok && ((fields.sport == PORT_HTTPS)
                                        || (fields.dport == PORT_HTTPS));
            MODE_DNS:   match = udp_ok && ((fields.sport == PORT_DNS)
                                        || (fields.dport == PORT_DNS));
            MODE_ARP:   match = eth_ok && (fields.ether_kind == ET_ARP);
            MODE_TCP:   match = l3_ok && (fields.proto == PROTO_TCP);
            MODE_UDP:   match = l3_ok && (fields.proto == PROTO_UDP);
            default:    match = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/ethernet_packet_class_filter.sv @@
// Ethernet packet class filter: takes a frame one byte per item and gives one
// match bit per frame at its last byte. Each byte is registered at the input,
// then one pass of logic updates the byte counter and the captured header
// fields (ethertype, IHL, protocol, ports) and, on the last byte, registers
// the match decision into the output register. One byte is taken every cycle
// unless the input stalls. The input stalls only when a last byte waits behind
// an untaken result. The filter mode is an APB register at byte address 0
// (bits 2:0) and is to be written by the user only while no frame is in
// flight; the block itself does not enforce this. Frames longer than 255
// bytes behave like 255-byte frames.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ethernet_packet_class_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // byte channel
    input  wire logic                              byte_valid,
    output logic                                   byte_stall,
    input  wire logic [7:0]                        frame_byte,
    input  wire logic                              frame_last,
    // result channel
    output logic                                   match_valid,
    input  wire logic                              match_stall,
    output logic                                   frame_match,
    // config port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [epcf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import epcf_pkg::*;

    // config register
    logic [2:0]  mode_reg;
    logic        cfg_write;

    // input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_advance;
    logic        byte_accept;

    // frame state
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [15:0] ether_kind_reg;
    logic [15:0] ether_kind_next;
    logic [3:0]  ihl_reg;
    logic [3:0]  ihl_next;
    logic [7:0]  proto_reg;
    logic [7:0]  proto_next;
    logic [15:0] sport_reg;
    logic [15:0] sport_next;
    logic [15:0] dport_reg;
    logic [15:0] dport_next;
    logic [7:0]  toff;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        match_reg;
    logic        match_now;

    frame_fields_t fields;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[CFG_ADDR_W-1];
    assign prdata    = paddr[CFG_ADDR_W-1] ? 32'd0 : {29'd0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_NONE;
        else if (cfg_write)
            mode_reg <= pwdata[2:0];
    end

    // handshake: a last byte waits only while the result register is blocked
    assign s1_advance  = s1_valid_reg && !(s1_last_reg && out_valid_reg && match_stall);
    assign byte_stall  = s1_valid_reg && !s1_advance;
    assign byte_accept = byte_valid && !byte_stall;

    always_comb
    begin
        if (byte_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            s1_byte_reg <= frame_byte;
            s1_last_reg <= frame_last;
        end
    end

    // field capture for the byte in the input register
    always_comb
    begin
        ether_kind_next = ether_kind_reg;
        ihl_next        = ihl_reg;
        proto_next      = proto_reg;
        sport_next      = sport_reg;
        dport_next      = dport_reg;

        if (count_reg == ET_HI_IDX)
            ether_kind_next[15:8] = s1_byte_reg;
        else if (count_reg == ET_LO_IDX)
            ether_kind_next[7:0] = s1_byte_reg;

        if (count_reg == IHL_IDX)
            ihl_next = s1_byte_reg[3:0];

        if ((count_reg == V6_NH_IDX) && (ether_kind_reg == ET_IPV6))
            proto_next = s1_byte_reg;
        if ((count_reg == V4_PROTO_IDX) && (ether_kind_reg == ET_IPV4))
            proto_next = s1_byte_reg;

        // transport offset sees an IHL taken from this same byte
        toff = (ether_kind_reg == ET_IPV6) ? (ETH_HDR_LEN + IPV6_HDR)
                                           : (ETH_HDR_LEN + {2'b00, ihl_next, 2'b00});
        if (count_reg >= ETH_HDR_LEN)
        begin
            if (count_reg == toff)
                sport_next[15:8] = s1_byte_reg;
            else if (count_reg == toff + 8'd1)
                sport_next[7:0] = s1_byte_reg;
            else if (count_reg == toff + 8'd2)
                dport_next[15:8] = s1_byte_reg;
            else if (count_reg == toff + 8'd3)
                dport_next[7:0] = s1_byte_reg;
        end

        // saturating byte counter
        count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 8'd1;
    end

    // frame state update, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ether_kind_reg <= '0;
            ihl_reg        <= '0;
            proto_reg      <= '0;
            sport_reg      <= '0;
            dport_reg      <= '0;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                count_reg      <= '0;
                ether_kind_reg <= '0;
                ihl_reg        <= '0;
                proto_reg      <= '0;
                sport_reg      <= '0;
                dport_reg      <= '0;
            end
            else
            begin
                count_reg      <= count_next;
                ether_kind_reg <= ether_kind_next;
                ihl_reg        <= ihl_next;
                proto_reg      <= proto_next;
                sport_reg      <= sport_next;
                dport_reg      <= dport_next;
            end
        end
    end

    // decision on the fields as they stand after the last byte
    assign fields = '{
        len:        count_next,
        ether_kind: ether_kind_next,
        ihl:        ihl_next,
        proto:      proto_next,
        sport:      sport_next,
        dport:      dport_next
    };

    epcf_decide u_decide (
        .mode   (mode_reg),
        .fields (fields),
        .match  (match_now)
    );

    // result register
    always_comb
    begin
        if (s1_advance && s1_last_reg)
            out_valid_next = 1'b1;
        else if (!match_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
            match_reg <= match_now;
    end

    assign match_valid = out_valid_reg;
    assign frame_match = match_reg;

    // checks
    `EPCF_ASSERT(a_stall_only_on_last,
        byte_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg),
        "input stalled without a blocked last item")
    `EPCF_ASSERT_NEXT(a_clear_after_last, s1_advance && s1_last_reg,
        count_reg == 8'd0 && ether_kind_reg == 16'd0 && proto_reg == 8'd0,
        "frame state not cleared after last item")
    `EPCF_ASSERT_NEXT(a_count_saturates,
        s1_advance && !s1_last_reg && count_reg == COUNT_MAX,
        count_reg == COUNT_MAX, "byte counter wrapped")
    `EPCF_ASSERT_NEXT(a_mode_none_matches,
        s1_advance && s1_last_reg && mode_reg == MODE_NONE,
        out_valid_reg && match_reg, "frame failed with filter none")

endmodule

`default_nettype wire
